>>> rtl/core/trd_pkg.sv
// trd_pkg: shared types and constants of the touch report decoder
// no dependencies; imported by every module in rtl/core
package trd_pkg;

	localparam int FRAME_BYTES   = 8;
	localparam int PAYLOAD_BYTES = FRAME_BYTES - 2;
	localparam int IDX_W         = $clog2(FRAME_BYTES);
	localparam int PL_IDX_W      = $clog2(PAYLOAD_BYTES);
	localparam int LAST_IDX      = FRAME_BYTES - 1;
	localparam int COORD_W       = 12;

	localparam logic [7:0]         HDR_MARK   = 8'h52;
	localparam logic [7:0]         BTN_NONE   = 8'hFF;
	localparam logic [COORD_W-1:0] COORD_FULL = 12'hFFF;

	// depth of the frame queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_GOOD     = 2'd0,
		ST_CHECKSUM = 2'd1,
		ST_HEADER   = 2'd2
	} trd_status_t;

	typedef enum logic [1:0] {
		KIND_NONE    = 2'd0,
		KIND_SINGLE  = 2'd1,
		KIND_TWO     = 2'd2,
		KIND_RELEASE = 2'd3
	} trd_kind_t;

	// one completed frame as handed from front to back
	typedef struct packed {
		logic                           sum_ok;
		logic                           hdr_ok;
		logic [PAYLOAD_BYTES-1:0][7:0]  payload;
	} trd_frame_t;

	// queue status seen by the back part
	typedef struct packed {
		logic       valid;
		trd_frame_t head;
	} trd_qhead_t;

	typedef struct packed {
		trd_status_t        status;
		trd_kind_t          kind;
		logic [COORD_W-1:0] first_x;
		logic [COORD_W-1:0] first_y;
		logic [COORD_W-1:0] second_x;
		logic [COORD_W-1:0] second_y;
		logic               button_report;
		logic [2:0]         button_mask;
		logic               buttons_released;
	} trd_result_t;

endpackage

>>> rtl/core/trd_front.sv
// trd_front: frame assembly, byte index, running sum and payload capture
// depends on trd_pkg; feeds trd_queue with one record per finished frame
module trd_front import trd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  logic [7:0] data_byte,
	input  logic       frame_start,
	output logic       rec_valid,
	output trd_frame_t rec
);

	logic [IDX_W-1:0]              byte_index_q;
	logic [7:0]                    sum_q;
	logic                          header_ok_q;
	logic                          in_frame_q;
	logic [PAYLOAD_BYTES-1:0][7:0] payload_q;

	logic [IDX_W-1:0] idx_eff;
	logic [7:0]       sum_eff;
	logic             active;
	logic             take;
	logic             last;

	always_comb begin
		idx_eff = frame_start ? '0 : byte_index_q;
		sum_eff = frame_start ? '0 : sum_q;
		active  = frame_start | in_frame_q;
		take    = push & ~full & active;
		last    = (idx_eff == IDX_W'(LAST_IDX));
	end

	assign rec_valid      = take & last;
	assign rec.sum_ok     = ((8'd0 - sum_eff) == data_byte);
	assign rec.hdr_ok     = header_ok_q;
	assign rec.payload    = payload_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= '0;
			sum_q        <= '0;
			header_ok_q  <= 1'b0;
			in_frame_q   <= 1'b0;
		end else if (take) begin
			if (last) begin
				byte_index_q <= '0;
				sum_q        <= '0;
				in_frame_q   <= 1'b0;
			end else begin
				byte_index_q <= idx_eff + IDX_W'(1);
				sum_q        <= sum_eff + data_byte;
				in_frame_q   <= 1'b1;
				if (idx_eff == '0) begin
					header_ok_q <= (data_byte == HDR_MARK);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && idx_eff != '0 && !last) begin
			payload_q[PL_IDX_W'(idx_eff - IDX_W'(1))] <= data_byte;
		end
	end

	// a nonzero index only exists inside an open frame
	a_idx_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		byte_index_q != '0 |-> in_frame_q)
		else $error("byte index advanced outside a frame");

endmodule

>>> rtl/core/trd_queue.sv
// trd_queue: short register queue of finished frames between front and back
// depends on trd_pkg
module trd_queue import trd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr,
	input  trd_frame_t wr_data,
	output logic       full,
	input  logic       rd,
	output trd_qhead_t head
);

	trd_frame_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]       wr_ptr_q;
	logic [QPTR_W-1:0]       rd_ptr_q;
	logic [QCNT_W-1:0]       count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.head  = mem_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		next_ptr = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (rd) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			unique case ({wr, rd})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr && full && !rd))
		else $error("frame queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd |-> head.valid)
		else $error("frame queue read while empty");

endmodule

>>> rtl/core/trd_back.sv
// trd_back: decodes queued frames into result items, holds the output register
// depends on trd_pkg; reads frames from trd_queue
module trd_back import trd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  trd_qhead_t  head,
	output logic        rd,
	output logic        empty,
	input  logic        pop,
	output trd_result_t result
);

	trd_result_t dec;
	trd_result_t res_q;
	logic        res_valid_q;

	logic [COORD_W-1:0] x, y, dx, dy;
	logic [7:0]         btn;
	logic               brep;
	trd_kind_t          kind;

	always_comb begin
		x    = {head.head.payload[0][7:4], head.head.payload[1]};
		y    = {head.head.payload[0][3:0], head.head.payload[2]};
		dx   = {head.head.payload[3][7:4], head.head.payload[4]};
		dy   = {head.head.payload[3][3:0], head.head.payload[5]};
		btn  = head.head.payload[4];
		brep = (x == COORD_FULL) && (y == COORD_FULL) && (btn != BTN_NONE);

		priority if (dx == '0 && dy == '0) begin
			kind = KIND_SINGLE;
		end else if (dx != COORD_FULL && dy != COORD_FULL) begin
			kind = KIND_TWO;
		end else begin
			kind = KIND_RELEASE;
		end

		dec = '0;
		priority if (!head.head.sum_ok) begin
			dec.status = ST_CHECKSUM;
			dec.kind   = KIND_NONE;
		end else if (!head.head.hdr_ok) begin
			dec.status = ST_HEADER;
			dec.kind   = KIND_NONE;
		end else begin
			dec.status           = ST_GOOD;
			dec.kind             = kind;
			dec.button_report    = brep;
			dec.button_mask      = brep ? btn[2:0] : 3'd0;
			dec.buttons_released = brep && (btn == 8'd0);
			if (kind != KIND_RELEASE) begin
				dec.first_x  = x;
				dec.first_y  = y;
				dec.second_x = dx;
				dec.second_y = dy;
			end
		end
	end

	// load a new result when the output register is free or being drained
	assign rd     = head.valid & (~res_valid_q | pop);
	assign empty  = ~res_valid_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (rd) begin
			res_valid_q <= 1'b1;
		end else if (pop) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd) begin
			res_q <= dec;
		end
	end

	a_bad_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.status != ST_GOOD |->
			res_q.kind == KIND_NONE && res_q.first_x == '0 && !res_q.button_report)
		else $error("bad frame carries decoded fields");

	a_release_coords: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.kind == KIND_RELEASE |->
			res_q.first_x == '0 && res_q.second_y == '0)
		else $error("release result carries coordinates");

endmodule

>>> rtl/core/touch_report_decoder.sv
// touch_report_decoder: top level, byte front end, frame queue and decoder back end
// depends on trd_pkg, trd_front, trd_queue, trd_back
//
//  channel  | handshake       | payload
//  ---------+-----------------+--------------------------------------------------
//  bytes in | push / full     | data_byte, frame_start
//  results  | empty / pop     | frame_status, touch_kind, first_x/y, second_x/y,
//           |                 | button_report, button_mask, buttons_released
//
// one byte is taken per cycle while full is low; a frame's last byte writes its
// record into the frame queue, from which the output register loads it when free or popped.
// full rises only when both frame queue slots and the output register hold
// undelivered frames, i.e. after three frames back up behind a stalled pop.
// arst_n clears the frame position, the queue and the output valid bit at once.
module touch_report_decoder import trd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         data_byte,
	input  logic               frame_start,
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         frame_status,
	output logic [1:0]         touch_kind,
	output logic [COORD_W-1:0] first_x,
	output logic [COORD_W-1:0] first_y,
	output logic [COORD_W-1:0] second_x,
	output logic [COORD_W-1:0] second_y,
	output logic               button_report,
	output logic [2:0]         button_mask,
	output logic               buttons_released
);

	logic        rec_valid;
	trd_frame_t  rec;
	logic        q_rd;
	trd_qhead_t  q_head;
	trd_result_t result;

	trd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.data_byte   (data_byte),
		.frame_start (frame_start),
		.rec_valid   (rec_valid),
		.rec         (rec)
	);

	trd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (rec_valid),
		.wr_data (rec),
		.full    (full),
		.rd      (q_rd),
		.head    (q_head)
	);

	trd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.rd     (q_rd),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	assign frame_status     = result.status;
	assign touch_kind       = result.kind;
	assign first_x          = result.first_x;
	assign first_y          = result.first_y;
	assign second_x         = result.second_x;
	assign second_y         = result.second_y;
	assign button_report    = result.button_report;
	assign button_mask      = result.button_mask;
	assign buttons_released = result.buttons_released;

endmodule

>>> test/tb_touch_report_decoder.sv
// tb_touch_report_decoder: self-checking testbench of the touch report decoder
// depends on trd_pkg and touch_report_decoder; a byte-level decoder model predicts
// each frame's report, which is checked against the result outputs in order
module tb_touch_report_decoder import trd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_BYTES = 1700;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic [7:0] data_byte = 8'h00;
	logic frame_start = 1'b0;
	logic full;
	logic empty;
	logic [1:0] frame_status;
	logic [1:0] touch_kind;
	logic [COORD_W-1:0] first_x;
	logic [COORD_W-1:0] first_y;
	logic [COORD_W-1:0] second_x;
	logic [COORD_W-1:0] second_y;
	logic button_report;
	logic [2:0] button_mask;
	logic buttons_released;

	touch_report_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.frame_start(frame_start),
		.empty(empty),
		.pop(pop),
		.frame_status(frame_status),
		.touch_kind(touch_kind),
		.first_x(first_x),
		.first_y(first_y),
		.second_x(second_x),
		.second_y(second_y),
		.button_report(button_report),
		.button_mask(button_mask),
		.buttons_released(buttons_released)
	);

	always #5 clk = ~clk;

	// decoder model state
	logic [IDX_W-1:0] fr_idx = '0;
	logic [7:0] fr_sum = 8'h00;
	logic fr_hdr = 1'b0;
	logic fr_open = 1'b0;
	logic [PAYLOAD_BYTES-1:0][7:0] fr_pl = '0;
	trd_result_t pending_reports[$];

	// idling controls
	int tx_gap_max = 0;
	int tx_burst_left = 0;
	int rx_stall_max = 0;
	int rx_left = 0;

	// bookkeeping
	int err_count = 0;
	int frame_bytes = 0;
	int n_good = 0;
	int n_cksum = 0;
	int n_hdr = 0;
	int n_kind[4] = '{0, 0, 0, 0};
	int n_buttons = 0;

	task automatic reassemble_byte(input logic [7:0] b, input logic s);
		trd_result_t r;
		logic [7:0] want_cs;
		logic [COORD_W-1:0] x, y, dx, dy;
		if (s) begin
			fr_idx = '0;
			fr_sum = 8'h00;
			fr_hdr = 1'b0;
			fr_open = 1'b1;
		end
		if (!fr_open)
			return;
		frame_bytes++;
		if (fr_idx == 0) begin
			fr_hdr = (b == HDR_MARK);
		end else if (fr_idx < LAST_IDX) begin
			fr_pl[fr_idx - 1] = b;
		end else begin
			want_cs = 8'h00 - fr_sum;
			fr_idx = '0;
			fr_sum = 8'h00;
			fr_open = 1'b0;
			r = '0;
			if (b != want_cs) begin
				r.status = ST_CHECKSUM;
			end else if (!fr_hdr) begin
				r.status = ST_HEADER;
			end else begin
				x = {fr_pl[0][7:4], fr_pl[1]};
				y = {fr_pl[0][3:0], fr_pl[2]};
				dx = {fr_pl[3][7:4], fr_pl[4]};
				dy = {fr_pl[3][3:0], fr_pl[5]};
				r.status = ST_GOOD;
				if (x == COORD_FULL && y == COORD_FULL && fr_pl[4] != BTN_NONE) begin
					r.button_report = 1'b1;
					r.button_mask = fr_pl[4][2:0];
					r.buttons_released = (fr_pl[4] == 8'h00);
				end
				if (dx == 0 && dy == 0)
					r.kind = KIND_SINGLE;
				else if (dx != COORD_FULL && dy != COORD_FULL)
					r.kind = KIND_TWO;
				else
					r.kind = KIND_RELEASE;
				if (r.kind != KIND_RELEASE) begin
					r.first_x = x;
					r.first_y = y;
					r.second_x = dx;
					r.second_y = dy;
				end
			end
			pending_reports.push_back(r);
			return;
		end
		fr_sum = fr_sum + b;
		fr_idx = fr_idx + 1'b1;
	endtask

	// one byte transaction; holds push across bursts, drops it for gaps
	task automatic send_byte(input logic [7:0] b, input logic s);
		push <= 1'b1;
		data_byte <= b;
		frame_start <= s;
		@(posedge clk);
		while (full)
			@(posedge clk);
		reassemble_byte(b, s);
		if (tx_gap_max == 0) begin
		end else if (tx_burst_left > 0) begin
			tx_burst_left--;
		end else begin
			push <= 1'b0;
			repeat ($urandom_range(1, tx_gap_max)) @(posedge clk);
			tx_burst_left = $urandom_range(0, 15);
		end
	endtask

	function automatic logic [PAYLOAD_BYTES-1:0][7:0] pack_points(
		input logic [11:0] x1, input logic [11:0] y1,
		input logic [11:0] x2, input logic [11:0] y2);
		logic [PAYLOAD_BYTES-1:0][7:0] p;
		p[0] = {x1[11:8], y1[11:8]};
		p[1] = x1[7:0];
		p[2] = y1[7:0];
		p[3] = {x2[11:8], y2[11:8]};
		p[4] = x2[7:0];
		p[5] = y2[7:0];
		return p;
	endfunction

	task automatic send_frame(input logic [7:0] hdr, input logic [PAYLOAD_BYTES-1:0][7:0] pl,
		input bit bad_sum);
		logic [7:0] cs;
		cs = 8'h00 - hdr;
		for (int i = 0; i < PAYLOAD_BYTES; i++)
			cs = cs - pl[i];
		if (bad_sum)
			cs = cs ^ 8'($urandom_range(1, 255));
		send_byte(hdr, 1'b1);
		for (int i = 0; i < PAYLOAD_BYTES; i++)
			send_byte(pl[i], 1'b0);
		send_byte(cs, 1'b0);
	endtask

	function automatic logic [11:0] pick_coord();
		case ($urandom_range(0, 5))
			0: return 12'h000;
			1: return 12'h001;
			2: return 12'hFFE;
			3: return COORD_FULL;
			default: return 12'($urandom);
		endcase
	endfunction

	task automatic compare_field(input string name, input logic [11:0] want_v,
		input logic [11:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			err_count++;
		end
	endtask

	// result checker and receiver stall pattern
	always @(posedge clk) begin
		trd_result_t w;
		if (arst_n && pop && !empty) begin
			if (pending_reports.size() == 0) begin
				$error("result transaction with no frame pending");
				err_count++;
			end else begin
				w = pending_reports.pop_front();
				compare_field("frame_status", 12'(w.status), 12'(frame_status));
				compare_field("touch_kind", 12'(w.kind), 12'(touch_kind));
				compare_field("first_x", w.first_x, first_x);
				compare_field("first_y", w.first_y, first_y);
				compare_field("second_x", w.second_x, second_x);
				compare_field("second_y", w.second_y, second_y);
				compare_field("button_report", 12'(w.button_report), 12'(button_report));
				compare_field("button_mask", 12'(w.button_mask), 12'(button_mask));
				compare_field("buttons_released", 12'(w.buttons_released),
					12'(buttons_released));
				case (w.status)
					ST_GOOD: n_good++;
					ST_CHECKSUM: n_cksum++;
					default: n_hdr++;
				endcase
				n_kind[w.kind]++;
				if (w.button_report)
					n_buttons++;
			end
		end
		if (rx_left > 0) begin
			rx_left--;
		end else if (rx_stall_max == 0) begin
			pop <= 1'b1;
		end else if (pop) begin
			pop <= 1'b0;
			rx_left = $urandom_range(0, rx_stall_max - 1);
		end else begin
			pop <= 1'b1;
			rx_left = $urandom_range(0, 9);
		end
	end

	task automatic test_touch_kinds();
		send_frame(HDR_MARK, pack_points(12'h000, 12'h000, 12'h000, 12'h000), 0);
		send_frame(HDR_MARK, pack_points(12'hABC, 12'h123, 12'h456, 12'h789), 0);
		send_frame(HDR_MARK, pack_points(12'hFFE, 12'hFFF, 12'hFFE, 12'hFFE), 0);
		send_frame(HDR_MARK, pack_points(12'h321, 12'h654, COORD_FULL, 12'h011), 0);
		send_frame(HDR_MARK, pack_points(12'h001, 12'h800, 12'h005, COORD_FULL), 0);
	endtask

	task automatic test_buttons();
		// all released, a mask, no report when the button byte is 0xff
		send_frame(HDR_MARK, pack_points(COORD_FULL, COORD_FULL, 12'h000, 12'h000), 0);
		send_frame(HDR_MARK, pack_points(COORD_FULL, COORD_FULL, 12'h105, 12'h000), 0);
		send_frame(HDR_MARK, pack_points(COORD_FULL, COORD_FULL, 12'h0FF, 12'h000), 0);
		// release with a button report still carried
		send_frame(HDR_MARK, pack_points(COORD_FULL, COORD_FULL, 12'h307, COORD_FULL), 0);
	endtask

	task automatic test_bad_frames();
		send_frame(HDR_MARK, pack_points(12'h111, 12'h222, 12'h333, 12'h444), 1);
		send_frame(8'h53, pack_points(12'h111, 12'h222, 12'h333, 12'h444), 0);
		send_frame(8'hFF, pack_points(12'hFFF, 12'hFFF, 12'h000, 12'h000), 0);
		// header and checksum both wrong: checksum is reported
		send_frame(8'h00, pack_points(12'h000, 12'h000, 12'h000, 12'h000), 1);
	endtask

	task automatic test_stray_and_restart();
		send_byte(8'hAA, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		// partial frame then a new frame
		send_byte(HDR_MARK, 1'b1);
		send_byte(8'h12, 1'b0);
		send_byte(8'h34, 1'b0);
		send_frame(HDR_MARK, pack_points(12'h0F0, 12'h00F, 12'h000, 12'h000), 0);
		// restart landing on the checksum position
		send_byte(HDR_MARK, 1'b1);
		for (int i = 0; i < PAYLOAD_BYTES; i++)
			send_byte(8'($urandom), 1'b0);
		send_frame(HDR_MARK, pack_points(12'h7FF, 12'h800, 12'h0AB, 12'hCDE), 0);
		// back-to-back starts
		send_byte(8'h52, 1'b1);
		send_byte(8'h52, 1'b1);
		send_frame(HDR_MARK, pack_points(12'h456, 12'h567, 12'h000, 12'h000), 0);
		send_byte(8'h5A, 1'b0);
	endtask

	task automatic test_random_frames();
		logic [PAYLOAD_BYTES-1:0][7:0] pl;
		logic [7:0] hdr;
		int sel;
		int target;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin tx_gap_max = 0; rx_stall_max = 0; end
				1: begin tx_gap_max = 4; rx_stall_max = 3; end
				2: begin tx_gap_max = 1; rx_stall_max = 30; end
				default: begin tx_gap_max = 8; rx_stall_max = 6; end
			endcase
			target = frame_bytes + RANDOM_BYTES / 4;
			while (frame_bytes < target) begin
				case ($urandom_range(0, 4))
					0: for (int i = 0; i < PAYLOAD_BYTES; i++) pl[i] = 8'($urandom);
					1: begin
						pl = pack_points(COORD_FULL, COORD_FULL, pick_coord(), pick_coord());
						if ($urandom_range(0, 2) == 0)
							pl[4] = ($urandom_range(0, 1) != 0) ? 8'h00 : BTN_NONE;
					end
					2: pl = pack_points(pick_coord(), pick_coord(), 12'h000, 12'h000);
					3: pl = pack_points(pick_coord(), pick_coord(), pick_coord(), COORD_FULL);
					default: pl = pack_points(pick_coord(), pick_coord(), pick_coord(),
						pick_coord());
				endcase
				sel = $urandom_range(0, 99);
				if (sel < 70) begin
					send_frame(HDR_MARK, pl, 0);
				end else if (sel < 78) begin
					hdr = ($urandom_range(0, 1) != 0) ? HDR_MARK : 8'($urandom);
					send_frame(hdr, pl, 1);
				end else if (sel < 86) begin
					hdr = 8'($urandom);
					if (hdr == HDR_MARK)
						hdr = ~hdr;
					send_frame(hdr, pl, 0);
				end else if (sel < 93) begin
					// truncated frame; the next start drops it
					send_byte(8'($urandom), 1'b1);
					repeat ($urandom_range(0, LAST_IDX - 1)) send_byte(8'($urandom), 1'b0);
				end else begin
					repeat ($urandom_range(1, 5)) send_byte(8'($urandom), 1'($urandom));
				end
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tx_gap_max = 3;
		rx_stall_max = 4;
		test_touch_kinds();
		test_buttons();
		test_bad_frames();
		test_stray_and_restart();
		test_random_frames();
		push <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		$display("sent %0d frame bytes; good %0d, checksum %0d, header %0d frames",
			frame_bytes, n_good, n_cksum, n_hdr);
		$display("kinds single %0d, two %0d, release %0d; button reports %0d",
			n_kind[KIND_SINGLE], n_kind[KIND_TWO], n_kind[KIND_RELEASE], n_buttons);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#5_000_000;
		$error("timeout with %0d reports pending", pending_reports.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/trd_pkg.sv
rtl/core/trd_front.sv
rtl/core/trd_queue.sv
rtl/core/trd_back.sv
rtl/core/touch_report_decoder.sv
test/tb_touch_report_decoder.sv
